### rtl/pidc_pkg.sv
// Shared types, constants and microcode for the PID position controller.
`default_nettype none

package pidc_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 4'd0,
		REG_GAIN_I         = 4'd1,
		REG_GAIN_D         = 4'd2,
		REG_TOLERANCE      = 4'd3,
		REG_MAX_ITERATIONS = 4'd4,
		REG_FULL_SCALE     = 4'd5,
		REG_POSITION_LIMIT = 4'd6,
		REG_ZERO_DRIVE     = 4'd7
	} reg_idx_t;

	localparam logic [7:0]  RST_GAIN_P         = 8'd40;
	localparam logic [7:0]  RST_GAIN_I         = 8'd4;
	localparam logic [7:0]  RST_GAIN_D         = 8'd5;
	localparam logic [15:0] RST_TOLERANCE      = 16'd50;
	localparam logic [15:0] RST_MAX_ITERATIONS = 16'd100;
	localparam logic [23:0] RST_FULL_SCALE     = 24'd110000;
	localparam logic [14:0] RST_POSITION_LIMIT = 15'd2048;
	localparam logic [7:0]  RST_ZERO_DRIVE     = 8'd128;

	// integral term clamp, +-2^62
	localparam logic signed [63:0] TERM_LIMIT = 64'sh4000_0000_0000_0000;

	localparam logic [7:0] DRIVE_MIN = 8'h00;
	localparam logic [7:0] DRIVE_MAX = 8'hFF;

	typedef enum logic [1:0] {
		ST_MOVING  = 2'd0,
		ST_REACHED = 2'd1,
		ST_GAVE_UP = 2'd2,
		ST_IDLE    = 2'd3
	} status_t;

	typedef logic [3:0] pc_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_TOL,
		OP_NEWT,
		OP_IDLECHK,
		OP_MAXCHK,
		OP_INTEG,
		OP_MULP,
		OP_MULI,
		OP_MULD,
		OP_SUMD,
		OP_MAP,
		OP_DIV,
		OP_OFFS,
		OP_COUNT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		CND_NONE,
		CND_ALWAYS,
		CND_REACHED,
		CND_DONE,
		CND_EXHAUST,
		CND_CLAMPED,
		CND_DIVBUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	localparam pc_t PC_WAIT    = 4'd0;
	localparam pc_t PC_TOL     = 4'd1;
	localparam pc_t PC_NEWT    = 4'd2;
	localparam pc_t PC_IDLECHK = 4'd3;
	localparam pc_t PC_MAXCHK  = 4'd4;
	localparam pc_t PC_INTEG   = 4'd5;
	localparam pc_t PC_MULP    = 4'd6;
	localparam pc_t PC_MULI    = 4'd7;
	localparam pc_t PC_MULD    = 4'd8;
	localparam pc_t PC_SUMD    = 4'd9;
	localparam pc_t PC_MAP     = 4'd10;
	localparam pc_t PC_DIV     = 4'd11;
	localparam pc_t PC_OFFS    = 4'd12;
	localparam pc_t PC_COUNT   = 4'd13;
	localparam pc_t PC_EMIT    = 4'd14;

	// control store: a taken condition jumps to target, else pc + 1
	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		case (pc)
			PC_WAIT:    w = '{OP_WAIT,    CND_NONE,    PC_WAIT};
			PC_TOL:     w = '{OP_TOL,     CND_REACHED, PC_EMIT};
			PC_NEWT:    w = '{OP_NEWT,    CND_NONE,    PC_WAIT};
			PC_IDLECHK: w = '{OP_IDLECHK, CND_DONE,    PC_EMIT};
			PC_MAXCHK:  w = '{OP_MAXCHK,  CND_EXHAUST, PC_EMIT};
			PC_INTEG:   w = '{OP_INTEG,   CND_NONE,    PC_WAIT};
			PC_MULP:    w = '{OP_MULP,    CND_NONE,    PC_WAIT};
			PC_MULI:    w = '{OP_MULI,    CND_NONE,    PC_WAIT};
			PC_MULD:    w = '{OP_MULD,    CND_NONE,    PC_WAIT};
			PC_SUMD:    w = '{OP_SUMD,    CND_NONE,    PC_WAIT};
			PC_MAP:     w = '{OP_MAP,     CND_CLAMPED, PC_COUNT};
			PC_DIV:     w = '{OP_DIV,     CND_DIVBUSY, PC_DIV};
			PC_OFFS:    w = '{OP_OFFS,    CND_NONE,    PC_WAIT};
			PC_COUNT:   w = '{OP_COUNT,   CND_NONE,    PC_WAIT};
			PC_EMIT:    w = '{OP_EMIT,    CND_ALWAYS,  PC_WAIT};
			default:    w = '{OP_NOP,     CND_ALWAYS,  PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/pidc_sample_if.sv
// Input channel: one target and encoder sample per transfer.
`default_nettype none

interface pidc_sample_if #(
	parameter int POSITION_BITS = 16
);
	logic                            valid;
	logic                            ready;
	logic signed [POSITION_BITS-1:0] target;
	logic signed [POSITION_BITS-1:0] measured;

	modport source(output valid, target, measured, input ready);
	modport sink(input valid, target, measured, output ready);
endinterface

`default_nettype wire

### rtl/pidc_drive_if.sv
// Output channel: one drive result per transfer.
`default_nettype none

interface pidc_drive_if;
	import pidc_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] drive_code;
	logic       drive_valid;
	status_t    status;

	modport source(output valid, drive_code, drive_valid, status, input ready);
	modport sink(input valid, drive_code, drive_valid, status, output ready);
endinterface

`default_nettype wire

### rtl/pid_position_controller.sv
// PID position controller: microcoded sequencer with one shared multiplier and divider.
`default_nettype none

// Takes one target/position sample per transfer and returns one drive result.
// A 16-entry microcode store steps a single datapath, one step per clock unless
// stalled: a sample within tolerance returns from the tolerance check, idle ones
// from the done check, gave-up ones from the iteration check; a clamped drive skips
// the divider and a scaled one runs the restoring divider for 127*out/full_scale.
// The next sample is taken once the sequencer is back at its wait step; the
// result sits in an output register, so a stalled consumer only blocks the final
// step. Configuration writes take effect at once and belong between samples.
module pid_position_controller #(
	parameter int POSITION_BITS    = 16,
	parameter int ACCUMULATOR_BITS = 40
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data,
	pidc_sample_if.sink                      sample,
	pidc_drive_if.source                     drive
);
	import pidc_pkg::*;

	localparam int EW     = POSITION_BITS + 1;
	localparam int DW     = POSITION_BITS + 2;
	localparam int OPW    = (ACCUMULATOR_BITS > DW) ? ACCUMULATOR_BITS : DW;
	localparam int PROD_W = OPW + 9;
	localparam int PROD_X = (PROD_W > 64) ? PROD_W : 64;
	localparam int PID_W  = (PROD_W + 2 > 64) ? 64 : PROD_W + 2;
	localparam int SW     = ((ACCUMULATOR_BITS > EW) ? ACCUMULATOR_BITS : EW) + 1;
	localparam int CW     = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
	localparam int MW     = (EW > 16) ? EW : 16;

	localparam logic signed [SW-1:0] ACC_MAX =
		{{(SW-ACCUMULATOR_BITS+1){1'b0}}, {(ACCUMULATOR_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [PROD_X-1:0] TERM_MAX = PROD_X'(TERM_LIMIT);
	localparam logic signed [PROD_X-1:0] TERM_MIN = -TERM_MAX;

	// configuration
	logic [7:0]  gain_p_q, gain_i_q, gain_d_q, zero_q;
	logic [15:0] tol_q, max_q;
	logic [23:0] fs_q;
	logic [14:0] lim_q;

	// control and loop state
	pc_t                               pc_q;
	logic signed [ACCUMULATOR_BITS-1:0] acc_q;
	logic signed [EW-1:0]              last_err_q;
	logic signed [POSITION_BITS-1:0]   last_tgt_q;
	logic [15:0]                       step_q;
	logic                              done_q;
	logic [2:0]                        div_cnt_q;
	logic                              out_valid_q;
	logic [7:0]                        out_code_q;
	logic                              out_dv_q;
	status_t                           out_st_q;

	// datapath
	logic signed [POSITION_BITS-1:0] tgt_q, pos_q;
	logic signed [EW-1:0]            err_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic signed [PID_W-1:0]         pid_q;
	logic [30:0]                     rem_q;
	logic [29:0]                     dv_q;
	logic [6:0]                      quo_q;
	logic [7:0]                      res_code_q;
	logic                            res_dv_q;
	status_t                         res_st_q;

	ctrl_t                    cw;
	logic                     in_ready, in_xfer, out_free, stall, jump;
	logic [EW-1:0]            mag;
	logic                     reached, new_target, exhausted;
	logic signed [CW-1:0]     pos_c, lim_c;
	logic                     clamp_lo, clamped;
	logic signed [SW-1:0]     acc_sum, acc_next;
	logic [7:0]               mul_a;
	logic signed [OPW-1:0]    mul_b;
	logic signed [DW-1:0]     diff;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_X-1:0] prod_x;
	logic signed [PID_W-1:0]  term, pid_sum;
	logic [30:0]              d127;
	logic                     div_ge;
	logic [8:0]               code_sum;

	assign cw       = ucode(pc_q);
	assign in_ready = (pc_q == PC_WAIT);
	assign in_xfer  = sample.valid && in_ready;
	assign out_free = !out_valid_q || drive.ready;

	assign sample.ready      = in_ready;
	assign drive.valid       = out_valid_q;
	assign drive.drive_code  = out_code_q;
	assign drive.drive_valid = out_dv_q;
	assign drive.status      = out_st_q;

	always_comb begin
		mag        = err_q[EW-1] ? -err_q : err_q;
		reached    = MW'(mag) < MW'(tol_q);
		new_target = (tgt_q != last_tgt_q);
		exhausted  = (step_q >= max_q);

		pos_c    = CW'(pos_q);
		lim_c    = CW'($signed({1'b0, lim_q}));
		clamp_lo = (pos_c > lim_c) || pid_q[PID_W-1];
		clamped  = clamp_lo || (pos_c < -lim_c) || (pid_q > $signed(PID_W'(fs_q)));

		acc_sum  = SW'(acc_q) + SW'(err_q);
		acc_next = (acc_sum > ACC_MAX) ? ACC_MAX : ((acc_sum < ACC_MIN) ? ACC_MIN : acc_sum);

		diff = DW'(err_q) - DW'(last_err_q);
		case (cw.op)
			OP_MULI: begin
				mul_a = gain_i_q;
				mul_b = OPW'(acc_q);
			end
			OP_MULD: begin
				mul_a = gain_d_q;
				mul_b = OPW'(diff);
			end
			default: begin
				mul_a = gain_p_q;
				mul_b = OPW'(err_q);
			end
		endcase
		mul_p = $signed({1'b0, mul_a}) * mul_b;

		prod_x  = PROD_X'(prod_q);
		term    = PID_W'((prod_x > TERM_MAX) ? TERM_MAX :
			((prod_x < TERM_MIN) ? TERM_MIN : prod_x));
		pid_sum = pid_q + term;

		d127     = {pid_q[23:0], 7'd0} - {7'd0, pid_q[23:0]};
		div_ge   = (fs_q != 24'd0) && (rem_q >= {1'b0, dv_q});
		code_sum = {1'b0, zero_q} + {2'b00, quo_q};

		case (cw.cond)
			CND_NONE:    jump = 1'b0;
			CND_ALWAYS:  jump = 1'b1;
			CND_REACHED: jump = reached;
			CND_DONE:    jump = done_q;
			CND_EXHAUST: jump = exhausted;
			CND_CLAMPED: jump = clamped;
			CND_DIVBUSY: jump = (div_cnt_q != 3'd0);
			default:     jump = 1'b0;
		endcase

		stall = ((cw.op == OP_WAIT) && !in_xfer) || ((cw.op == OP_EMIT) && !out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= RST_GAIN_P;
			gain_i_q <= RST_GAIN_I;
			gain_d_q <= RST_GAIN_D;
			tol_q    <= RST_TOLERANCE;
			max_q    <= RST_MAX_ITERATIONS;
			fs_q     <= RST_FULL_SCALE;
			lim_q    <= RST_POSITION_LIMIT;
			zero_q   <= RST_ZERO_DRIVE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN_P:         gain_p_q <= cfg_data[7:0];
				REG_GAIN_I:         gain_i_q <= cfg_data[7:0];
				REG_GAIN_D:         gain_d_q <= cfg_data[7:0];
				REG_TOLERANCE:      tol_q    <= cfg_data[15:0];
				REG_MAX_ITERATIONS: max_q    <= cfg_data[15:0];
				REG_FULL_SCALE:     fs_q     <= cfg_data[23:0];
				REG_POSITION_LIMIT: lim_q    <= cfg_data[14:0];
				REG_ZERO_DRIVE:     zero_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_WAIT;
			acc_q       <= '0;
			last_err_q  <= '0;
			last_tgt_q  <= '0;
			step_q      <= '0;
			done_q      <= 1'b1;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_code_q  <= '0;
			out_dv_q    <= 1'b0;
			out_st_q    <= ST_IDLE;
		end else begin
			if (!stall)
				pc_q <= jump ? cw.target : pc_q + 4'd1;
			if (out_valid_q && drive.ready && (cw.op != OP_EMIT))
				out_valid_q <= 1'b0;
			case (cw.op)
				OP_TOL: begin
					if (reached)
						done_q <= 1'b1;
				end
				OP_NEWT: begin
					if (new_target) begin
						step_q     <= '0;
						acc_q      <= '0;
						last_err_q <= err_q;
						last_tgt_q <= tgt_q;
						done_q     <= 1'b0;
					end
				end
				OP_MAXCHK: begin
					if (exhausted)
						done_q <= 1'b1;
				end
				OP_INTEG: acc_q <= ACCUMULATOR_BITS'(acc_next);
				OP_MAP: begin
					if (!clamped)
						div_cnt_q <= 3'd6;
				end
				OP_DIV: begin
					if (div_cnt_q != 3'd0)
						div_cnt_q <= div_cnt_q - 3'd1;
				end
				OP_COUNT: step_q <= step_q + 16'd1;
				OP_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_code_q  <= res_code_q;
						out_dv_q    <= res_dv_q;
						out_st_q    <= res_st_q;
						last_err_q  <= err_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tgt_q <= sample.target;
			pos_q <= sample.measured;
			err_q <= EW'(sample.target) - EW'(sample.measured);
		end
		case (cw.op)
			OP_TOL: begin
				res_code_q <= zero_q;
				res_dv_q   <= 1'b1;
				res_st_q   <= ST_REACHED;
			end
			OP_IDLECHK: begin
				res_code_q <= zero_q;
				res_dv_q   <= 1'b0;
				res_st_q   <= ST_IDLE;
			end
			OP_MAXCHK: begin
				res_code_q <= zero_q;
				res_dv_q   <= 1'b1;
				res_st_q   <= ST_GAVE_UP;
			end
			OP_MULP: prod_q <= mul_p;
			OP_MULI: begin
				pid_q  <= term;
				prod_q <= mul_p;
			end
			OP_MULD: begin
				pid_q  <= pid_sum;
				prod_q <= mul_p;
			end
			OP_SUMD: pid_q <= pid_sum;
			OP_MAP: begin
				res_code_q <= clamp_lo ? DRIVE_MIN : DRIVE_MAX;
				rem_q      <= d127;
				dv_q       <= {fs_q, 6'd0};
				quo_q      <= '0;
			end
			OP_DIV: begin
				if (div_ge)
					rem_q <= rem_q - {1'b0, dv_q};
				quo_q <= {quo_q[5:0], div_ge};
				dv_q  <= dv_q >> 1;
			end
			OP_OFFS: res_code_q <= code_sum[8] ? DRIVE_MAX : code_sum[7:0];
			OP_COUNT: begin
				res_dv_q <= 1'b1;
				res_st_q <= ST_MOVING;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> pc_q == PC_TOL)
		else $error("sample transfer did not start the sequence");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q) == PC_EMIT)
		else $error("result raised outside the emit step");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q != 3'd0 |-> pc_q == PC_DIV)
		else $error("divider count live outside the divide step");

	a_moving_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_EMIT && res_st_q == ST_MOVING) |-> !done_q)
		else $error("moving result while target marked done");
`endif

endmodule

`default_nettype wire

### tb/pidc_checker.sv
// Checker for the PID position controller: predicts each drive result and compares it.
`timescale 1ns / 1ps

module pidc_checker #(
	parameter int ACC_BITS = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data,
	pidc_sample_if                          sample,
	pidc_drive_if                           drive,
	output int                              pending,
	output int                              failures
);
	import pidc_pkg::*;

	typedef struct packed {
		logic [7:0] code;
		logic       dvalid;
		status_t    st;
	} drive_t;

	localparam longint ACC_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	logic [7:0]  kp, ki, kd, zdrive;
	logic [15:0] tol, iter_max;
	logic [23:0] fscale;
	logic [14:0] plimit;

	longint             integ;
	longint             prev_err;
	logic signed [15:0] held_tgt;
	int                 steps;
	bit                 settled;

	drive_t expected_drives[$];
	int     bad = 0;

	assign failures = bad;

	function automatic drive_t control_step(input logic signed [15:0] tgt,
			input logic signed [15:0] meas);
		longint e, mag, pos, lim, ti, pid, q, code, gp, gi, gd, fs, tl, lim_i;
		int     cap;
		drive_t r;
		e = longint'(tgt) - longint'(meas);
		mag = (e < 0) ? -e : e;
		pos = meas;
		lim = plimit;
		gp = kp;
		gi = ki;
		gd = kd;
		fs = fscale;
		tl = tol;
		cap = iter_max;
		r = '{zdrive, 1'b1, ST_REACHED};
		if (mag < tl) begin
			settled = 1'b1;
			prev_err = e;
			return r;
		end
		if (tgt != held_tgt) begin
			steps = 0;
			integ = 0;
			prev_err = e;
			held_tgt = tgt;
			settled = 1'b0;
		end
		if (settled) begin
			r.dvalid = 1'b0;
			r.st = ST_IDLE;
			prev_err = e;
			return r;
		end
		if (steps >= cap) begin
			settled = 1'b1;
			r.st = ST_GAVE_UP;
			prev_err = e;
			return r;
		end

		if (e > 0 && integ > ACC_MAX - e)
			integ = ACC_MAX;
		else if (e < 0 && integ < ACC_MIN - e)
			integ = ACC_MIN;
		else
			integ = integ + e;

		lim_i = (gi != 0) ? TERM_LIMIT / gi : 0;
		if (gi != 0 && integ > lim_i)
			ti = TERM_LIMIT;
		else if (gi != 0 && integ < -lim_i)
			ti = -TERM_LIMIT;
		else
			ti = gi * integ;

		pid = gp * e + ti + gd * (e - prev_err);

		if (pos > lim || pid < 0) begin
			code = DRIVE_MIN;
		end else if (pos < -lim || pid > fs) begin
			code = DRIVE_MAX;
		end else begin
			q = (fs != 0) ? (127 * pid) / fs : 0;
			code = longint'(zdrive) + q;
			if (code > longint'(DRIVE_MAX))
				code = DRIVE_MAX;
		end

		r = '{code[7:0], 1'b1, ST_MOVING};
		steps++;
		prev_err = e;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			kp = RST_GAIN_P;
			ki = RST_GAIN_I;
			kd = RST_GAIN_D;
			tol = RST_TOLERANCE;
			iter_max = RST_MAX_ITERATIONS;
			fscale = RST_FULL_SCALE;
			plimit = RST_POSITION_LIMIT;
			zdrive = RST_ZERO_DRIVE;
			integ = 0;
			prev_err = 0;
			held_tgt = '0;
			steps = 0;
			settled = 1'b1;
			expected_drives.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_P:         kp = cfg_data[7:0];
					REG_GAIN_I:         ki = cfg_data[7:0];
					REG_GAIN_D:         kd = cfg_data[7:0];
					REG_TOLERANCE:      tol = cfg_data[15:0];
					REG_MAX_ITERATIONS: iter_max = cfg_data[15:0];
					REG_FULL_SCALE:     fscale = cfg_data[23:0];
					REG_POSITION_LIMIT: plimit = cfg_data[14:0];
					REG_ZERO_DRIVE:     zdrive = cfg_data[7:0];
					default: ;
				endcase
			end

			if (sample.valid === 1'b1 && sample.ready === 1'b1)
				expected_drives.push_back(control_step(sample.target, sample.measured));

			if (drive.valid === 1'b1 && drive.ready === 1'b1) begin
				if (expected_drives.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%0t: unexpected transfer: code %0d valid %0b status %0d",
							$realtime, drive.drive_code, drive.drive_valid, drive.status);
				end else begin
					want = expected_drives.pop_front();
					if (drive.drive_code !== want.code || drive.drive_valid !== want.dvalid ||
							drive.status !== want.st) begin
						bad++;
						if (bad <= 10)
							$display("%0t: mismatch exp %0d %0b %0d got %0d %0b %0d",
								$realtime, want.code, want.dvalid, want.st,
								drive.drive_code, drive.drive_valid, drive.status);
					end
				end
			end

			pending <= expected_drives.size();
		end
	end

endmodule

### tb/tb_top.sv
// Top-level bench for pid_position_controller: clock, reset, configuration, sample and drive traffic.
`timescale 1ns / 1ps

module tb_top;
	import pidc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int REG_COUNT   = 8;
	localparam int HOLD_PERIOD = 9000;
	localparam int HOLD_START  = 2500;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		MIX_HIGH,
		MIX_LOW,
		MIX_NO_SCALE,
		MIX_RANDOM
	} cfg_mix_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    pending;
	int                    failures;

	int cycles     = 0;
	int items_sent = 0;
	int burst_left = 0;
	int rx_cnt;
	int hold_left;
	int cur_limit  = RST_POSITION_LIMIT;
	int cur_iter   = RST_MAX_ITERATIONS;
	int cur_tol    = RST_TOLERANCE;
	int prev_tgt   = 0;

	pidc_sample_if #(.POSITION_BITS(16)) smp ();
	pidc_drive_if drv ();

	pid_position_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (smp),
		.drive     (drv)
	);

	pidc_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (smp),
		.drive     (drv),
		.pending   (pending),
		.failures  (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("pid_position_controller verification failed");
			$finish;
		end
	end

	// consumer: phased stall patterns plus a periodic long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv.ready <= 1'b0;
			rx_cnt <= 0;
			hold_left <= 0;
		end else begin
			rx_cnt <= rx_cnt + 1;
			if (hold_left != 0) begin
				drv.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (rx_cnt % HOLD_PERIOD == HOLD_START) begin
				drv.ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
			end else begin
				case ((rx_cnt / 1024) % 4)
					0:       drv.ready <= 1'b1;
					1:       drv.ready <= 1'($urandom_range(0, 1));
					2:       drv.ready <= (rx_cnt % 3) != 0;
					default: drv.ready <= (rx_cnt % 8) == 0;
				endcase
			end
		end
	end

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int pick(input int lo, input int hi, input int mid);
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return mid;
	endfunction

	task automatic send_sample(input logic signed [15:0] t, input logic signed [15:0] m);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		smp.valid <= 1'b1;
		smp.target <= t;
		smp.measured <= m;
		@(posedge clk);
		while (smp.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
		logic [CFG_DATA_W-1:0] keep;
		keep = (width >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << width) - 1);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
		@(posedge clk);
	endtask

	task automatic program_regs(input cfg_mix_t mix);
		int kp, ki, kd, tol, iter, fs, lim, zd, sel;
		case (mix)
			MIX_HIGH: begin
				kp = 255; ki = 255; kd = 255;
				tol = 0; iter = 65535; fs = 24'hFFFFFF; lim = 32767; zd = 255;
			end
			MIX_LOW: begin
				kp = 0; ki = 0; kd = 0;
				tol = 65535; iter = 0; fs = 0; lim = 0; zd = 0;
			end
			MIX_NO_SCALE: begin
				kp = $urandom_range(0, 255); ki = $urandom_range(0, 255);
				kd = $urandom_range(0, 255);
				tol = $urandom_range(0, 100); iter = 20; fs = 0; lim = 32767;
				zd = $urandom_range(0, 255);
			end
			default: begin
				kp = pick(0, 255, $urandom_range(0, 255));
				ki = pick(0, 255, $urandom_range(0, 40));
				kd = pick(0, 255, $urandom_range(0, 255));
				tol = pick(0, 65535, $urandom_range(0, 300));
				iter = pick(0, 65535, $urandom_range(1, 60));
				sel = $urandom_range(0, 2);
				fs = (sel == 0) ? $urandom_range(1, 2000) :
					(sel == 1) ? $urandom_range(50000, 300000) : $urandom_range(1, 24'hFFFFFF);
				fs = pick(1, 24'hFFFFFF, fs);
				lim = pick(0, 32767, $urandom_range(100, 32767));
				zd = pick(0, 255, $urandom_range(0, 255));
			end
		endcase
		write_reg(REG_GAIN_P, kp, 8);
		write_reg(REG_GAIN_I, ki, 8);
		write_reg(REG_GAIN_D, kd, 8);
		write_reg(REG_TOLERANCE, tol, 16);
		write_reg(REG_MAX_ITERATIONS, iter, 16);
		write_reg(REG_FULL_SCALE, fs, 24);
		write_reg(REG_POSITION_LIMIT, lim, 15);
		write_reg(REG_ZERO_DRIVE, zd, 8);
		// unmapped index, must not disturb anything
		write_reg($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1), $urandom, CFG_DATA_W);
		cfg_we <= 1'b0;
		cur_limit = lim;
		cur_iter = iter;
		cur_tol = tol;
	endtask

	// one target held while the position walks toward it
	task automatic run_target();
		int t, p, span, len, i, off, frac, jit;
		span = cur_limit + 64;
		if (span > 32767)
			span = 32767;
		if ($urandom_range(0, 7) == 0) begin
			t = prev_tgt;
		end else if ($urandom_range(0, 5) == 0) begin
			t = $urandom_range(0, 65535);
			t = t - 32768;
		end else begin
			t = $urandom_range(0, 2 * span);
			t = t - span;
		end
		off = $urandom_range(0, 4 * span + 200);
		p = clamp16(t + off - (2 * span + 100));
		if (cur_iter <= 150 && $urandom_range(0, 5) == 0)
			len = cur_iter + $urandom_range(1, 6);
		else
			len = $urandom_range(1, 24);
		for (i = 0; i < len; i++) begin
			send_sample(16'(t), 16'(p));
			frac = $urandom_range(0, 7);
			jit = $urandom_range(0, 2 * cur_tol + 8);
			jit = jit - (cur_tol + 4);
			p = clamp16(p + (t - p) * frac / 8 + jit);
		end
		prev_tgt = t;
	endtask

	task automatic random_phase(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) == 0)
				send_sample(16'($urandom), 16'($urandom));
			else
				run_target();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GAIN_P;
		cfg_data <= '0;
		smp.valid <= 1'b0;
		smp.target <= '0;
		smp.measured <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle start, reached, moving, limits, tolerance edge
		send_sample(0, 1000);
		send_sample(0, -10);
		send_sample(1000, 0);
		send_sample(1000, 500);
		send_sample(1000, 950);
		send_sample(1000, 951);
		send_sample(1000, 0);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(-32768, -32768);
		send_sample(32767, 32767);
		send_sample(0, 2048);
		send_sample(0, -2048);
		send_sample(0, -2049);
		send_sample(21845, -21846);
		send_sample(-21846, 21845);
		send_sample(100, 50);
		send_sample(100, 49);
		send_sample(100, 150);
		send_sample(100, 101);
		random_phase(150);

		drain();
		program_regs(MIX_HIGH);
		random_phase(150);

		// no steps allowed: full-span error escapes the widest tolerance and gives up
		drain();
		program_regs(MIX_LOW);
		send_sample(32767, -32768);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		random_phase(40);

		drain();
		program_regs(MIX_NO_SCALE);
		random_phase(120);

		repeat (6) begin
			drain();
			program_regs(MIX_RANDOM);
			random_phase(125);
		end

		drain();
		repeat (32) @(posedge clk);
		if (failures == 0)
			$display("pid_position_controller verification clean");
		else
			$display("pid_position_controller verification failed");
		$finish;
	end

endmodule
